/* rtl/msra_pkg.sv */
// ============================================================================
// msra_pkg
// Shared widths, operation codes and defaults of the running average table.
// ============================================================================
package msra_pkg;

    // Field widths of the channels
    localparam int OP_W     = 2;
    localparam int SLOT_W   = 8;
    localparam int SAMPLE_W = 48;
    localparam int AVG_W    = 48;
    localparam int WIN_W    = 16;

    // Accumulator width of one slot
    localparam int ACC_W = 64;

    // Number of slots the slot field can address
    localparam int SLOT_RANGE = 1 << SLOT_W;

    // Parameter defaults
    localparam int SLOTS_DEF        = 256;
    localparam int SAMPLE_WIDTH_DEF = 48;

    // Operation codes; the unused code acts as a read
    localparam logic [OP_W-1:0] OP_UPDATE = 2'd0;
    localparam logic [OP_W-1:0] OP_READ   = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

    // Largest average the output field can carry
    localparam logic [ACC_W-1:0] AVG_MAX = (ACC_W'(1) << AVG_W) - ACC_W'(1);

endpackage

/* rtl/msra_if.sv */
// ============================================================================
// msra_if
// Valid/ready channels of the running average table: request, result and
// window configuration.
// ============================================================================

// Request channel: one operation on one slot
interface msra_in_if;
    import msra_pkg::*;
    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     operation;
    logic [SLOT_W-1:0]   slot;
    logic [SAMPLE_W-1:0] sample;

    modport source (output valid, operation, slot, sample, input ready);
    modport sink   (input valid, operation, slot, sample, output ready);
endinterface

// Result channel: average and fill flag of the slot
interface msra_out_if;
    import msra_pkg::*;
    logic             valid;
    logic             ready;
    logic [AVG_W-1:0] average;
    logic             slot_valid;

    modport source (output valid, average, slot_valid, input ready);
    modport sink   (input valid, average, slot_valid, output ready);
endinterface

// Configuration channel: window length
interface msra_cfg_if;
    import msra_pkg::*;
    logic             valid;
    logic             ready;
    logic [WIN_W-1:0] window_count;

    modport source (output valid, window_count, input ready);
    modport sink   (input valid, window_count, output ready);
endinterface

/* rtl/multi_slot_running_average.sv */
// Flow: a read of a filled slot divides the accumulator by the window; an update of
//   a filled slot divides, subtracts, adds the sample, writes back and divides again;
//   the first update of an empty slot writes the seed and divides it; a clear or an
//   empty read skips the shared 2-bit-per-cycle divider. One word at a time: the next
//   word is taken in the cycle after the result enters the output register.
// Reset: valid flags cleared, window 1, output empty; accumulator RAM not cleared.
// ============================================================================
// multi_slot_running_average
// Table of exponential running averages, one scaled accumulator per slot,
// kept in a RAM and updated by read-modify-write through a shared divider.
// ============================================================================
module multi_slot_running_average #(
    parameter int SLOTS        = msra_pkg::SLOTS_DEF,
    parameter int SAMPLE_WIDTH = msra_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    msra_cfg_if.sink          i_cfg,
    msra_in_if.sink           i_in,
    msra_out_if.source        o_out
);
    import msra_pkg::*;

    // Only slots the slot field can reach need storage
    localparam int MEM_DEPTH = (SLOTS > SLOT_RANGE) ? SLOT_RANGE : SLOTS;
    localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int DIV_CYC   = ACC_W / 2;
    localparam int CNT_W     = $clog2(DIV_CYC);
    localparam int PROD_W    = SAMPLE_WIDTH + WIN_W;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_READ  = 8'b0000_0010,
        S_DIV   = 8'b0000_0100,
        S_SUB   = 8'b0000_1000,
        S_ADD   = 8'b0001_0000,
        S_WRITE = 8'b0010_0000,
        S_ROUND = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } t_state;

    // Control state
    t_state                r_state, n_state;
    logic [MEM_DEPTH-1:0]  r_valid;
    logic [WIN_W-1:0]      r_window;
    logic [CNT_W-1:0]      r_cnt;
    logic                  r_upd;
    logic                  r_out_valid;

    // Payload registers
    logic [OP_W-1:0]         r_op;
    logic [ADDR_W-1:0]       r_addr;
    logic                    r_in_range;
    logic [SAMPLE_WIDTH-1:0] r_sample;
    logic [ACC_W-1:0]        r_acc;
    logic [ACC_W-1:0]        r_quot;
    logic [WIN_W-1:0]        r_rem;
    logic [AVG_W-1:0]        r_avg;
    logic                    r_res_sv;
    logic [AVG_W-1:0]        r_out_avg;
    logic                    r_out_sv;

    // Combinational helpers
    logic                  in_acc;
    logic                  in_range;
    logic [WIN_W-1:0]      w_eff;
    logic [ACC_W-1:0]      rd_data;
    logic                  slot_filled;
    logic [PROD_W-1:0]     prod;
    logic [WIN_W:0]        t1, t2;
    logic                  ge1, ge2;
    logic [WIN_W-1:0]      rem1, rem2;
    logic                  rnd_up;
    logic [ACC_W-1:0]      avg_full;
    logic [ACC_W:0]        sum;
    logic                  div_last;
    logic                  out_free;

    // Handshakes
    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = (r_state == S_IDLE);
    assign in_acc      = i_in.valid && (r_state == S_IDLE);
    assign in_range    = (32'(i_in.slot) < SLOTS);
    assign out_free    = !r_out_valid || o_out.ready;

    assign o_out.valid      = r_out_valid;
    assign o_out.average    = r_out_avg;
    assign o_out.slot_valid = r_out_sv;

    // Zero window acts as one
    assign w_eff = (r_window == '0) ? WIN_W'(1) : r_window;

    // Accumulator memory
    msra_ram #(
        .WIDTH  (ACC_W),
        .DEPTH  (MEM_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_acc_ram (
        .i_clk     (i_clk),
        .i_wr_en   (r_state == S_WRITE),
        .i_wr_addr (r_addr),
        .i_wr_data (r_acc),
        .i_rd_en   (in_acc),
        .i_rd_addr (i_in.slot[ADDR_W-1:0]),
        .o_rd_data (rd_data)
    );

    assign slot_filled = r_in_range && r_valid[r_addr];

    // First sample scaled by the window; always fits the accumulator
    assign prod = {{WIN_W{1'b0}}, r_sample} * {{SAMPLE_WIDTH{1'b0}}, w_eff};

    // Two restoring division steps per cycle
    always_comb begin
        t1   = {r_rem, r_quot[ACC_W-1]};
        ge1  = (t1 >= {1'b0, w_eff});
        rem1 = ge1 ? WIN_W'(t1 - {1'b0, w_eff}) : t1[WIN_W-1:0];
        t2   = {rem1, r_quot[ACC_W-2]};
        ge2  = (t2 >= {1'b0, w_eff});
        rem2 = ge2 ? WIN_W'(t2 - {1'b0, w_eff}) : t2[WIN_W-1:0];
    end

    assign div_last = (r_cnt == CNT_W'(DIV_CYC - 1));

    // Round half up: remainder at least half the window
    assign rnd_up   = ({r_rem, 1'b0} >= {1'b0, w_eff});
    assign avg_full = r_quot + ACC_W'(rnd_up);

    // Saturating add of the new sample
    assign sum = {1'b0, r_acc} + (ACC_W + 1)'(r_sample);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) n_state = S_READ;
            end
            S_READ: begin
                if (!r_in_range || r_op == OP_CLEAR) begin
                    n_state = S_DONE;
                end else if (r_op == OP_UPDATE) begin
                    n_state = slot_filled ? S_DIV : S_WRITE;
                end else begin
                    n_state = slot_filled ? S_DIV : S_DONE;
                end
            end
            S_DIV: begin
                if (div_last) n_state = r_upd ? S_SUB : S_ROUND;
            end
            S_SUB:   n_state = S_ADD;
            S_ADD:   n_state = S_WRITE;
            S_WRITE: n_state = S_DIV;
            S_ROUND: n_state = S_DONE;
            S_DONE: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_window    <= WIN_W'(1);
            r_cnt       <= '0;
            r_upd       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg.valid) begin
                r_window <= i_cfg.window_count;
            end

            // Valid flag changes on clear and first update
            if (r_state == S_READ && r_in_range) begin
                if (r_op == OP_CLEAR) begin
                    r_valid[r_addr] <= 1'b0;
                end else if (r_op == OP_UPDATE) begin
                    r_valid[r_addr] <= 1'b1;
                end
            end

            // Division pass bookkeeping
            if (r_state == S_READ) begin
                r_upd <= (r_op == OP_UPDATE);
                r_cnt <= '0;
            end else if (r_state == S_WRITE) begin
                r_upd <= 1'b0;
                r_cnt <= '0;
            end else if (r_state == S_DIV) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end

            // Output register
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    r_op       <= i_in.operation;
                    r_addr     <= i_in.slot[ADDR_W-1:0];
                    r_in_range <= in_range;
                    r_sample   <= i_in.sample[SAMPLE_WIDTH-1:0];
                end
            end
            S_READ: begin
                r_avg    <= '0;
                r_rem    <= '0;
                r_quot   <= rd_data;
                // Update always leaves the slot filled; a read reports the flag
                r_res_sv <= r_in_range && ((r_op == OP_UPDATE) ||
                                           (r_op != OP_CLEAR && slot_filled));
                // First sample of an empty slot is seeded with sample * w
                r_acc    <= (r_op == OP_UPDATE && !slot_filled) ? ACC_W'(prod) : rd_data;
            end
            S_DIV: begin
                r_quot <= {r_quot[ACC_W-3:0], ge1, ge2};
                r_rem  <= rem2;
            end
            S_SUB: begin
                // acc - round(acc / w)
                r_acc <= r_acc - avg_full;
            end
            S_ADD: begin
                r_acc <= sum[ACC_W] ? '1 : sum[ACC_W-1:0];
            end
            S_WRITE: begin
                r_quot <= r_acc;
                r_rem  <= '0;
            end
            S_ROUND: begin
                r_avg <= (avg_full > AVG_MAX) ? AVG_MAX[AVG_W-1:0] : avg_full[AVG_W-1:0];
            end
            S_DONE: begin
                if (out_free) begin
                    r_out_avg <= r_avg;
                    r_out_sv  <= r_res_sv;
                end
            end
            default: begin
                r_rem <= r_rem;
            end
        endcase
    end

endmodule

/* rtl/msra_ram.sv */
// ============================================================================
// msra_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read.
// ============================================================================
module msra_ram #(
    parameter int WIDTH  = 64,
    parameter int DEPTH  = 256,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/msra_check.sv */
// ============================================================================
// msra_check
// Port-level checks of the running average table, bound to the top level.
// ============================================================================
module msra_check (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       i_in_ready,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input logic [msra_pkg::AVG_W-1:0] i_out_average,
    input logic                       i_out_slot_valid
);
    import msra_pkg::*;

    // Reset empties the output register
    a_rst_out: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result word present after reset");

    // Stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_average) && $stable(i_out_slot_valid))
        else $error("stalled result word changed");

    // Empty slot reports a zero average
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_slot_valid |-> i_out_average == '0)
        else $error("nonzero average for empty slot");

    // One request in flight: ready drops after a word is taken
    a_one_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("request taken while busy");

endmodule

bind multi_slot_running_average msra_check u_msra_check (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in.valid),
    .i_in_ready       (i_in.ready),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_out_average    (o_out.average),
    .i_out_slot_valid (o_out.slot_valid)
);
